// File: rtl/core/plfs_pkg.sv
`timescale 1ns / 1ps
// Package for the priority level FIFO set: sizes, codes, payload structs
// and the command and status structs between controller and datapath.
// No dependencies.
package plfs_pkg;

  localparam int NUM_LEVELS  = 4;
  localparam int LEVEL_DEPTH = 64;
  localparam int ADDR_WIDTH  = 64;

  localparam int LVL_W     = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int PTR_W     = $clog2(LEVEL_DEPTH);
  localparam int CNT_W     = $clog2(LEVEL_DEPTH + 1);
  localparam int MEM_DEPTH = NUM_LEVELS * LEVEL_DEPTH;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);

  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic        action;
    logic [1:0]  level;
    logic [63:0] addr;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  out_level;
    logic [63:0] out_addr;
  } rsp_t;

  typedef enum logic {
    S_IDLE,
    S_READ
  } ctrl_state_t;

  typedef struct packed {
    logic accept;
    logic load_now;
    logic load_ram;
  } plfs_cmd_t;

  typedef struct packed {
    logic pop_hit;
  } plfs_sts_t;

endpackage

// File: rtl/core/priority_level_fifo_set_top.sv
`timescale 1ns / 1ps
// Top level of the priority level FIFO set: controller plus datapath.
// Depends on plfs_pkg, plfs_ctrl and plfs_dp.
//
// Usage:
// The req channel carries one command per transfer: a push appends addr to
// the queue of its level, a pop takes the oldest address of the
// lowest-numbered non-empty level. Every command gives exactly one transfer
// on the rsp channel with a status, the level and the popped address.
// A push, a push to a full level and a pop with every level empty answer in
// the cycle after the transfer; the next command can follow in the next cycle.
// A pop that finds an entry reads the entry RAM through its registered read
// port and the S_READ state before the result register; req_ready is low in
// S_READ, so no new command is taken until such a pop has been read.
// The result sits in an output register; a new command is taken while it
// waits, as long as rsp_ready is high in that cycle. While rsp_ready stays
// low with a result pending, req_ready stays low.
// Reset empties every queue at once by clearing the counts and head
// pointers; the entry RAM is not cleared and no warm-up is needed.
module priority_level_fifo_set_top (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  plfs_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output plfs_pkg::rsp_t rsp
);

  plfs_pkg::plfs_cmd_t cmd;
  plfs_pkg::plfs_sts_t sts;

  plfs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  plfs_dp u_dp (
    .clk(clk),
    .rst(rst),
    .req(req),
    .cmd(cmd),
    .sts(sts),
    .rsp(rsp)
  );

  a_pop_two_cycles: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && sts.pop_hit) |=> (!req_ready && !rsp_valid) ##1 rsp_valid)
    else $error("pop with an entry did not answer two cycles later");

  a_fast_answer: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && !sts.pop_hit) |=> rsp_valid)
    else $error("push or empty pop did not answer in the next cycle");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.status == plfs_pkg::ST_DONE || rsp.status == plfs_pkg::ST_EMPTY ||
                   rsp.status == plfs_pkg::ST_FULL))
    else $error("result carries an unknown status code");

  a_failed_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status != plfs_pkg::ST_DONE) |-> (rsp.out_addr == 64'd0 &&
                                                        rsp.out_level == 2'd0))
    else $error("failed command returned a nonzero level or address");

endmodule

// File: rtl/core/plfs_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module plfs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic                                         re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/plfs_ctrl.sv
`timescale 1ns / 1ps
// Controller for the priority level FIFO set: handshakes and sequencing.
// Depends on plfs_pkg.
module plfs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  input  plfs_pkg::plfs_sts_t sts,
  output plfs_pkg::plfs_cmd_t cmd
);

  plfs_pkg::ctrl_state_t state, state_next;
  logic rsp_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= plfs_pkg::S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_comb begin
    state_next   = state;
    req_ready    = 1'b0;
    cmd.accept   = 1'b0;
    cmd.load_now = 1'b0;
    cmd.load_ram = 1'b0;
    case (state)
      plfs_pkg::S_IDLE: begin
        req_ready  = !rsp_valid || rsp_ready;
        cmd.accept = req_valid && req_ready;
        if (cmd.accept) begin
          if (sts.pop_hit) begin
            state_next = plfs_pkg::S_READ;
          end else begin
            cmd.load_now = 1'b1;
          end
        end
      end
      plfs_pkg::S_READ: begin
        cmd.load_ram = 1'b1;
        state_next   = plfs_pkg::S_IDLE;
      end
      default: begin
        state_next = plfs_pkg::S_IDLE;
      end
    endcase
    if (cmd.load_now || cmd.load_ram) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_ready) begin
      rsp_valid_next = 1'b0;
    end else begin
      rsp_valid_next = rsp_valid;
    end
  end

endmodule

// File: rtl/core/plfs_dp.sv
`timescale 1ns / 1ps
// Datapath for the priority level FIFO set: ring pointers, counts, the
// entry RAM, the priority encoder and the result register.
// Depends on plfs_pkg and plfs_ram.
module plfs_dp (
  input  logic                clk,
  input  logic                rst,
  input  plfs_pkg::req_t      req,
  input  plfs_pkg::plfs_cmd_t cmd,
  output plfs_pkg::plfs_sts_t sts,
  output plfs_pkg::rsp_t      rsp
);

  logic [plfs_pkg::CNT_W-1:0] level_count [plfs_pkg::NUM_LEVELS];
  logic [plfs_pkg::PTR_W-1:0] head_index  [plfs_pkg::NUM_LEVELS];
  logic [plfs_pkg::NUM_LEVELS-1:0] nonempty;
  logic [plfs_pkg::LVL_W-1:0] sel_level;
  logic [plfs_pkg::LVL_W-1:0] idx;
  logic [plfs_pkg::LVL_W-1:0] pend_level;
  logic [plfs_pkg::CNT_W-1:0] cur_count;
  logic [plfs_pkg::PTR_W-1:0] cur_head;
  logic [plfs_pkg::PTR_W-1:0] head_inc;
  logic [plfs_pkg::CNT_W:0] tail_sum;
  logic [plfs_pkg::PTR_W-1:0] ptr;
  logic [plfs_pkg::MEM_AW-1:0] mem_addr;
  logic any_nonempty;
  logic is_pop;
  logic push_ok;
  logic do_push;
  logic do_pop;
  logic [plfs_pkg::ADDR_WIDTH-1:0] rdata;
  plfs_pkg::rsp_t now_rsp;

  always_comb begin
    sel_level = '0;
    for (int i = plfs_pkg::NUM_LEVELS - 1; i >= 0; i--) begin
      nonempty[i] = level_count[i] != '0;
      if (nonempty[i]) begin
        sel_level = plfs_pkg::LVL_W'(i);
      end
    end
  end

  assign any_nonempty = |nonempty;
  assign is_pop       = req.action == plfs_pkg::ACT_POP;
  assign idx          = is_pop ? sel_level : plfs_pkg::LVL_W'(req.level);
  assign cur_count    = level_count[idx];
  assign cur_head     = head_index[idx];
  assign push_ok      = (32'(req.level) < plfs_pkg::NUM_LEVELS) &&
                        (cur_count != plfs_pkg::CNT_W'(plfs_pkg::LEVEL_DEPTH));
  assign do_push      = cmd.accept && !is_pop && push_ok;
  assign do_pop       = cmd.accept && is_pop && any_nonempty;
  assign sts.pop_hit  = is_pop && any_nonempty;

  always_comb begin
    tail_sum = (plfs_pkg::CNT_W + 1)'(cur_head) + (plfs_pkg::CNT_W + 1)'(cur_count);
    if (tail_sum >= (plfs_pkg::CNT_W + 1)'(plfs_pkg::LEVEL_DEPTH)) begin
      tail_sum = tail_sum - (plfs_pkg::CNT_W + 1)'(plfs_pkg::LEVEL_DEPTH);
    end
    if (cur_head == plfs_pkg::PTR_W'(plfs_pkg::LEVEL_DEPTH - 1)) begin
      head_inc = '0;
    end else begin
      head_inc = cur_head + plfs_pkg::PTR_W'(1);
    end
    ptr      = is_pop ? cur_head : tail_sum[plfs_pkg::PTR_W-1:0];
    mem_addr = plfs_pkg::MEM_AW'(idx) * plfs_pkg::MEM_AW'(plfs_pkg::LEVEL_DEPTH)
               + plfs_pkg::MEM_AW'(ptr);
  end

  plfs_ram #(
    .WIDTH(plfs_pkg::ADDR_WIDTH),
    .DEPTH(plfs_pkg::MEM_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (do_push),
    .waddr(mem_addr),
    .wdata(plfs_pkg::ADDR_WIDTH'(req.addr)),
    .re   (do_pop),
    .raddr(mem_addr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < plfs_pkg::NUM_LEVELS; i++) begin
        level_count[i] <= '0;
        head_index[i]  <= '0;
      end
    end else begin
      for (int i = 0; i < plfs_pkg::NUM_LEVELS; i++) begin
        if (idx == plfs_pkg::LVL_W'(i)) begin
          if (do_push) begin
            level_count[i] <= level_count[i] + plfs_pkg::CNT_W'(1);
          end else if (do_pop) begin
            level_count[i] <= level_count[i] - plfs_pkg::CNT_W'(1);
            head_index[i]  <= head_inc;
          end
        end
      end
    end
  end

  always_comb begin
    now_rsp.out_level = 2'd0;
    now_rsp.out_addr  = 64'd0;
    if (is_pop) begin
      now_rsp.status = plfs_pkg::ST_EMPTY;
    end else if (push_ok) begin
      now_rsp.status = plfs_pkg::ST_DONE;
    end else begin
      now_rsp.status = plfs_pkg::ST_FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (do_pop) begin
      pend_level <= sel_level;
    end
    if (cmd.load_now) begin
      rsp <= now_rsp;
    end else if (cmd.load_ram) begin
      rsp.status    <= plfs_pkg::ST_DONE;
      rsp.out_level <= 2'(pend_level);
      rsp.out_addr  <= 64'(rdata);
    end
  end

endmodule
